@@ src/dmsp_pkg.sv @@
// Shared types, constants and register map of the dual motor synced position loop.
package dmsp_pkg;

    // Default build widths
    localparam int POSITION_BITS_DEF   = 16;
    localparam int DUTY_BITS_DEF       = 16;
    localparam int TICK_COUNT_BITS_DEF = 16;

    // Fixed fractional formats
    localparam int POS_FRAC       = 12;
    localparam int GAIN_FRAC      = 12;
    localparam int CFG_POS_BITS   = 16;
    localparam int GAIN_BITS      = 16;
    localparam int DUTY_MAG_BITS  = 15;
    localparam int FACTOR_BITS    = POS_FRAC + GAIN_FRAC + 1;
    localparam int TIMEOUT_BITS   = 16;

    // APB map
    localparam int APB_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_TARGET   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_DUTY = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MIN_DUTY = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_APP_GAIN = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SYN_GAIN = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_TOL      = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_DEADBAND = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_TIMEOUT  = 3'd7;

    // Reset values
    localparam logic [CFG_POS_BITS-1:0]  RST_TARGET   = 16'd0;
    localparam logic [DUTY_MAG_BITS-1:0] RST_MAX_DUTY = 15'd26214;
    localparam logic [DUTY_MAG_BITS-1:0] RST_MIN_DUTY = 15'd3932;
    localparam logic [GAIN_BITS-1:0]     RST_APP_GAIN = 16'd12288;
    localparam logic [GAIN_BITS-1:0]     RST_SYN_GAIN = 16'd5325;
    localparam logic [14:0]              RST_TOL      = 15'd492;
    localparam logic [14:0]              RST_DEADBAND = 15'd328;
    localparam logic [TIMEOUT_BITS-1:0]  RST_TIMEOUT  = 16'd2000;

    typedef enum logic [1:0] {
        ST_MOVING  = 2'd0,
        ST_REACHED = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_CANCEL  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CFG_POS_BITS-1:0] target_position;
        logic [DUTY_MAG_BITS-1:0]       max_duty;
        logic [DUTY_MAG_BITS-1:0]       min_duty;
        logic [GAIN_BITS-1:0]           approach_gain;
        logic [GAIN_BITS-1:0]           sync_gain;
        logic [14:0]                    tolerance;
        logic [14:0]                    deadband;
        logic [TIMEOUT_BITS-1:0]        timeout_ticks;
    } t_cfg;

endpackage

@@ src/dmsp_in_if.sv @@
// Tick channel: both measured positions plus start and cancel flags.
interface dmsp_in_if
    import dmsp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] left_position;
    logic signed [POSITION_BITS-1:0] right_position;
    logic                            start_move;
    logic                            cancel;

    modport source (
        output valid, left_position, right_position, start_move, cancel,
        input  ready
    );
    modport sink (
        input  valid, left_position, right_position, start_move, cancel,
        output ready
    );
endinterface

@@ src/dmsp_out_if.sv @@
// Result channel: signed duty commands and move status.
interface dmsp_out_if
    import dmsp_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [DUTY_BITS-1:0] left_duty;
    logic signed [DUTY_BITS-1:0] right_duty;
    logic [1:0]                  move_status;

    modport source (
        output valid, left_duty, right_duty, move_status,
        input  ready
    );
    modport sink (
        input  valid, left_duty, right_duty, move_status,
        output ready
    );
endinterface

@@ src/dmsp_mul.sv @@
// Shared unsigned multiplier with registered product.
module dmsp_mul #(
    parameter int A_BITS = 25,
    parameter int B_BITS = 16
) (
    input  logic                     i_clk,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic [A_BITS+B_BITS-1:0] o_p
);
    logic [A_BITS+B_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_BITS+B_BITS)'(i_a) * (A_BITS+B_BITS)'(i_b);
    end

    assign o_p = r_p;
endmodule

@@ src/dmsp_regs.sv @@
// APB configuration register file.
module dmsp_regs
    import dmsp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);
    t_cfg                    r_cfg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[CFG_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_position <= RST_TARGET;
            r_cfg.max_duty        <= RST_MAX_DUTY;
            r_cfg.min_duty        <= RST_MIN_DUTY;
            r_cfg.approach_gain   <= RST_APP_GAIN;
            r_cfg.sync_gain       <= RST_SYN_GAIN;
            r_cfg.tolerance       <= RST_TOL;
            r_cfg.deadband        <= RST_DEADBAND;
            r_cfg.timeout_ticks   <= RST_TIMEOUT;
        end else if (wr_en) begin
            unique case (idx)
                REG_TARGET:   r_cfg.target_position <= pwdata[15:0];
                REG_MAX_DUTY: r_cfg.max_duty        <= pwdata[14:0];
                REG_MIN_DUTY: r_cfg.min_duty        <= pwdata[14:0];
                REG_APP_GAIN: r_cfg.approach_gain   <= pwdata[15:0];
                REG_SYN_GAIN: r_cfg.sync_gain       <= pwdata[15:0];
                REG_TOL:      r_cfg.tolerance       <= pwdata[14:0];
                REG_DEADBAND: r_cfg.deadband        <= pwdata[14:0];
                REG_TIMEOUT:  r_cfg.timeout_ticks   <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TARGET:   prdata = APB_DATA_BITS'(r_cfg.target_position);
            REG_MAX_DUTY: prdata = APB_DATA_BITS'(r_cfg.max_duty);
            REG_MIN_DUTY: prdata = APB_DATA_BITS'(r_cfg.min_duty);
            REG_APP_GAIN: prdata = APB_DATA_BITS'(r_cfg.approach_gain);
            REG_SYN_GAIN: prdata = APB_DATA_BITS'(r_cfg.sync_gain);
            REG_TOL:      prdata = APB_DATA_BITS'(r_cfg.tolerance);
            REG_DEADBAND: prdata = APB_DATA_BITS'(r_cfg.deadband);
            REG_TIMEOUT:  prdata = APB_DATA_BITS'(r_cfg.timeout_ticks);
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

@@ src/dmsp_core.sv @@
// Tick sequencer: status decision, duty math over the shared multiplier, output word.
module dmsp_core
    import dmsp_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int DUTY_BITS       = DUTY_BITS_DEF,
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    dmsp_in_if.sink    i_cmd,
    dmsp_out_if.source o_res
);
    localparam int PW  = (POSITION_BITS > CFG_POS_BITS) ? POSITION_BITS : CFG_POS_BITS;
    localparam int AW  = (PW > FACTOR_BITS) ? PW : FACTOR_BITS;
    localparam int PRW = AW + GAIN_BITS;
    localparam int TW  = (TICK_COUNT_BITS > TIMEOUT_BITS) ? TICK_COUNT_BITS : TIMEOUT_BITS;
    localparam int PROD_SHIFT = POS_FRAC + GAIN_FRAC - (DUTY_BITS - 1);
    localparam int SW  = DUTY_BITS + DUTY_MAG_BITS + 1;
    localparam logic [PRW-1:0] SYNC_ONE = PRW'(1) << (POS_FRAC + GAIN_FRAC);
    localparam logic [SW-1:0]  DUTY_MAX_MAG = (SW'(1) << (DUTY_BITS - 1)) - SW'(1);
    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_MUL_L, S_MUL_R, S_MUL_C, S_MUL_S, S_SYNC, S_DONE
    } t_state;

    t_state                         r_state;
    logic signed [POSITION_BITS-1:0] r_lpos, r_rpos;
    logic                           r_start, r_cancel;
    logic [TICK_COUNT_BITS-1:0]     r_tick;
    t_status                        r_finish;
    t_status                        r_status;
    logic [PW-1:0]                  r_lerr, r_rerr, r_mis;
    logic                           r_ldone, r_rdone, r_sync_on, r_mis_pos, r_forward;
    logic [DUTY_MAG_BITS-1:0]       r_lduty, r_rduty;
    logic                           r_out_valid;
    logic signed [DUTY_BITS-1:0]    r_out_left, r_out_right;
    t_status                        r_out_status;

    // evaluation datapath
    logic signed [PW:0]         lpos_x, rpos_x, tgt_x, ldiff, rdiff, mdiff;
    logic [PW:0]                labs, rabs, mabs;
    logic [PW-1:0]              lerr, rerr, mis_mag;
    logic                       ldone, rdone;
    t_status                    fs0, n_finish;
    logic [TICK_COUNT_BITS-1:0] tc0, n_tick;
    logic                       accept, out_load;

    // multiplier
    logic [AW-1:0]        mul_a;
    logic [GAIN_BITS-1:0] mul_b;
    logic [PRW-1:0]       prod;
    logic [PRW-1:0]       factor_w;
    logic [DUTY_MAG_BITS-1:0] sync_duty;

    function automatic logic [DUTY_MAG_BITS-1:0] f_clamp(
        input logic [PRW-1:0]           p,
        input logic [DUTY_MAG_BITS-1:0] lo_lim,
        input logic [DUTY_MAG_BITS-1:0] hi_lim
    );
        logic [PRW-1:0] sh, lo, hi;
        sh = p >> PROD_SHIFT;
        lo = (sh < PRW'(lo_lim)) ? PRW'(lo_lim) : sh;
        hi = (lo > PRW'(hi_lim)) ? PRW'(hi_lim) : lo;
        return hi[DUTY_MAG_BITS-1:0];
    endfunction

    function automatic logic signed [DUTY_BITS-1:0] f_signed(
        input logic [DUTY_MAG_BITS-1:0] mag,
        input logic                     pos
    );
        logic [SW-1:0]        w;
        logic [DUTY_BITS-1:0] m;
        w = SW'(mag);
        if (w > DUTY_MAX_MAG) begin
            w = DUTY_MAX_MAG;
        end
        m = w[DUTY_BITS-1:0];
        return pos ? m : -m;
    endfunction

    assign accept   = i_cmd.valid & i_cmd.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // errors and mismatch, sign-extended to a common width
    always_comb begin
        lpos_x  = {{(PW + 1 - POSITION_BITS){r_lpos[POSITION_BITS-1]}}, r_lpos};
        rpos_x  = {{(PW + 1 - POSITION_BITS){r_rpos[POSITION_BITS-1]}}, r_rpos};
        tgt_x   = {{(PW + 1 - CFG_POS_BITS){i_cfg.target_position[CFG_POS_BITS-1]}},
                   i_cfg.target_position};
        ldiff   = lpos_x - tgt_x;
        rdiff   = rpos_x - tgt_x;
        mdiff   = rpos_x - lpos_x;
        labs    = ldiff[PW] ? -ldiff : ldiff;
        rabs    = rdiff[PW] ? -rdiff : rdiff;
        mabs    = mdiff[PW] ? -mdiff : mdiff;
        lerr    = labs[PW-1:0];
        rerr    = rabs[PW-1:0];
        mis_mag = mabs[PW-1:0];
        ldone   = lerr <= PW'(i_cfg.tolerance);
        rdone   = rerr <= PW'(i_cfg.tolerance);
    end

    // move status: start clears, held end wins, then cancel, timeout, reached
    always_comb begin
        fs0 = r_start ? ST_MOVING : r_finish;
        tc0 = r_start ? '0 : r_tick;
        n_finish = fs0;
        n_tick   = tc0;
        if (fs0 == ST_MOVING) begin
            if (r_cancel) begin
                n_finish = ST_CANCEL;
            end else if (TW'(tc0) > TW'(i_cfg.timeout_ticks)) begin
                n_finish = ST_TIMEOUT;
            end else if (ldone && rdone) begin
                n_finish = ST_REACHED;
            end else begin
                n_tick = (tc0 == TICK_MAX) ? tc0 : tc0 + 1'b1;
            end
        end
    end

    // slowdown factor 1 - sync_gain*|mismatch|, floored at zero
    assign factor_w  = (prod >= SYNC_ONE) ? '0 : SYNC_ONE - prod;
    assign sync_duty = prod[POS_FRAC + GAIN_FRAC +: DUTY_MAG_BITS];

    always_comb begin
        unique case (r_state)
            S_MUL_L: begin
                mul_a = AW'(r_lerr);
                mul_b = i_cfg.approach_gain;
            end
            S_MUL_R: begin
                mul_a = AW'(r_rerr);
                mul_b = i_cfg.approach_gain;
            end
            S_MUL_C: begin
                mul_a = AW'(r_mis);
                mul_b = i_cfg.sync_gain;
            end
            S_MUL_S: begin
                mul_a = AW'(factor_w[FACTOR_BITS-1:0]);
                mul_b = GAIN_BITS'(i_cfg.max_duty);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dmsp_mul #(
        .A_BITS (AW),
        .B_BITS (GAIN_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_finish    <= ST_MOVING;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_lpos   <= i_cmd.left_position;
                        r_rpos   <= i_cmd.right_position;
                        r_start  <= i_cmd.start_move;
                        r_cancel <= i_cmd.cancel;
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_finish  <= n_finish;
                    r_tick    <= n_tick;
                    r_status  <= n_finish;
                    r_lerr    <= lerr;
                    r_rerr    <= rerr;
                    r_mis     <= mis_mag;
                    r_ldone   <= ldone;
                    r_rdone   <= rdone;
                    r_sync_on <= mis_mag > PW'(i_cfg.deadband);
                    r_mis_pos <= !mdiff[PW] && (mdiff != '0);
                    r_forward <= tgt_x > lpos_x;
                    r_lduty   <= '0;
                    r_rduty   <= '0;
                    r_state   <= (n_finish == ST_MOVING) ? S_MUL_L : S_DONE;
                end
                S_MUL_L: begin
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_lduty <= r_ldone ? '0 : f_clamp(prod, i_cfg.min_duty, i_cfg.max_duty);
                    r_state <= S_MUL_C;
                end
                S_MUL_C: begin
                    r_rduty <= r_rdone ? '0 : f_clamp(prod, i_cfg.min_duty, i_cfg.max_duty);
                    r_state <= S_MUL_S;
                end
                S_MUL_S: begin
                    r_state <= S_SYNC;
                end
                S_SYNC: begin
                    // leading motor takes the slowed duty
                    if (r_sync_on) begin
                        if (r_mis_pos) begin
                            r_rduty <= sync_duty;
                        end else begin
                            r_lduty <= sync_duty;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_left   <= f_signed(r_lduty, r_forward);
                        r_out_right  <= f_signed(r_rduty, r_forward);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.left_duty   = r_out_left;
    assign o_res.right_duty  = r_out_right;
    assign o_res.move_status = r_out_status;

`ifndef SYNTHESIS
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result word appeared outside the done step");

    a_end_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_MOVING) |-> (r_out_left == '0 && r_out_right == '0))
        else $error("ended move carries nonzero duty");

    a_same_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !((r_out_left > 0 && r_out_right < 0)
                       || (r_out_left < 0 && r_out_right > 0)))
        else $error("duties point in opposite directions");

    a_finish_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EVAL) |=> $stable(r_finish))
        else $error("end status changed outside evaluation");
`endif
endmodule

@@ src/dual_motor_synced_position_loop_top.sv @@
// Top level of the dual motor synced position loop: APB registers and tick sequencer.
// Sequence: a moving tick steps through evaluation, four passes through the single
//   shared multiplier (two approach products, the mismatch product and the slowdown
//   scaling), the sync step and the done step; a tick that ends or has ended the move
//   (reached, timed out, cancelled) goes from evaluation straight to the done step. A new
//   tick is taken only back in idle, and the done step holds while the output stalls.
// Reset (i_rst_n low, synchronous): registers take their defaults, tick count and end
//   status clear to moving, no result word is pending, and the tick input is ready.
module dual_motor_synced_position_loop_top
    import dmsp_pkg::*;
#(
    parameter int POSITION_BITS   = POSITION_BITS_DEF,
    parameter int DUTY_BITS       = DUTY_BITS_DEF,
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // tick words in, duty words out
    dmsp_in_if.sink                  i_cmd,
    dmsp_out_if.source               o_res
);
    t_cfg cfg;

    // Register file; the user must write it only while no tick is in flight, the block itself does not enforce this.
    dmsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: evaluates status, then steps the shared multiplier for
    // both approach duties and the sync slowdown of the leading motor.
    dmsp_core #(
        .POSITION_BITS   (POSITION_BITS),
        .DUTY_BITS       (DUTY_BITS),
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );
endmodule

@@ test/dmsp_tick_checker.sv @@
// Checker for the dual motor position loop: register shadow, duty prediction, word compare.
`timescale 1ns / 1ps

module dmsp_tick_checker
    import dmsp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    dmsp_in_if                       i_cmd,
    dmsp_out_if                      i_res,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_words_checked,
    output int                       o_reached,
    output int                       o_timed_out,
    output int                       o_cancelled
);

    localparam int DUTY_FRAC  = DUTY_BITS_DEF - 1;
    localparam int PROD_SHIFT = POS_FRAC + GAIN_FRAC - DUTY_FRAC;
    localparam int UNITY_BITS = POS_FRAC + GAIN_FRAC;
    localparam logic [32:0] UNITY = 33'd1 << UNITY_BITS;

    typedef struct packed {
        logic signed [DUTY_BITS_DEF-1:0] left_duty;
        logic signed [DUTY_BITS_DEF-1:0] right_duty;
        t_status                         status;
    } t_duty_word;

    t_cfg                             regs;
    logic [TICK_COUNT_BITS_DEF-1:0]   tick_cnt;
    t_status                          end_state;
    t_duty_word                       duty_q [$];
    int                               fails;
    int                               words;
    int                               n_reached;
    int                               n_timed_out;
    int                               n_cancelled;

    // error magnitude times approach gain, clamped to [min, max]; max wins if crossed
    function automatic logic [DUTY_MAG_BITS-1:0] approach_mag(input logic [16:0] err);
        logic [32:0] prod;
        logic [23:0] mag;
        prod = 33'(err) * 33'(regs.approach_gain);
        mag = 24'(prod >> PROD_SHIFT);
        if (mag < 24'(regs.min_duty)) mag = 24'(regs.min_duty);
        if (mag > 24'(regs.max_duty)) mag = 24'(regs.max_duty);
        return mag[DUTY_MAG_BITS-1:0];
    endfunction

    // one tick: advances the move state and returns the duty word it yields
    function automatic t_duty_word predict_duties(
        input logic signed [15:0] lpos,
        input logic signed [15:0] rpos,
        input logic               start,
        input logic               abort
    );
        logic signed [16:0]       l_diff;
        logic signed [16:0]       r_diff;
        logic signed [16:0]       skew;
        logic [16:0]              l_err;
        logic [16:0]              r_err;
        logic [16:0]              skew_mag;
        logic                     l_done;
        logic                     r_done;
        logic                     fwd;
        logic [DUTY_MAG_BITS-1:0] l_mag;
        logic [DUTY_MAG_BITS-1:0] r_mag;
        logic [32:0]              corr;
        logic [24:0]              factor;
        logic [39:0]              scaled;
        t_duty_word               w;

        w.left_duty  = '0;
        w.right_duty = '0;
        w.status     = ST_MOVING;

        if (start) begin
            tick_cnt  = '0;
            end_state = ST_MOVING;
        end
        if (end_state == ST_MOVING) begin
            if (abort) end_state = ST_CANCEL;
            else if (tick_cnt > regs.timeout_ticks) end_state = ST_TIMEOUT;
        end
        if (end_state != ST_MOVING) begin
            w.status = end_state;
            return w;
        end

        l_diff = 17'(lpos) - 17'($signed(regs.target_position));
        r_diff = 17'(rpos) - 17'($signed(regs.target_position));
        l_err  = l_diff[16] ? 17'(-l_diff) : 17'(l_diff);
        r_err  = r_diff[16] ? 17'(-r_diff) : 17'(r_diff);
        l_done = l_err <= 17'(regs.tolerance);
        r_done = r_err <= 17'(regs.tolerance);

        if (l_done && r_done) begin
            end_state = ST_REACHED;
            w.status  = ST_REACHED;
            return w;
        end

        fwd   = $signed(regs.target_position) > lpos;
        l_mag = l_done ? '0 : approach_mag(l_err);
        r_mag = r_done ? '0 : approach_mag(r_err);

        // leading motor slowed by the mismatch, even when it sits in tolerance
        skew     = 17'(rpos) - 17'(lpos);
        skew_mag = skew[16] ? 17'(-skew) : 17'(skew);
        if (skew_mag > 17'(regs.deadband)) begin
            corr   = 33'(skew_mag) * 33'(regs.sync_gain);
            factor = (corr >= UNITY) ? '0 : 25'(UNITY - corr);
            scaled = 40'(regs.max_duty) * 40'(factor);
            if (!skew[16]) r_mag = DUTY_MAG_BITS'(scaled >> UNITY_BITS);
            else           l_mag = DUTY_MAG_BITS'(scaled >> UNITY_BITS);
        end

        w.left_duty  = fwd ? $signed({1'b0, l_mag}) : -$signed({1'b0, l_mag});
        w.right_duty = fwd ? $signed({1'b0, r_mag}) : -$signed({1'b0, r_mag});

        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_duty_word want;
        logic       bad;
        if (!i_rst_n) begin
            regs.target_position <= RST_TARGET;
            regs.max_duty        <= RST_MAX_DUTY;
            regs.min_duty        <= RST_MIN_DUTY;
            regs.approach_gain   <= RST_APP_GAIN;
            regs.sync_gain       <= RST_SYN_GAIN;
            regs.tolerance       <= RST_TOL;
            regs.deadband        <= RST_DEADBAND;
            regs.timeout_ticks   <= RST_TIMEOUT;
            tick_cnt    = '0;
            end_state   = ST_MOVING;
            duty_q.delete();
            fails       = 0;
            words       = 0;
            n_reached   = 0;
            n_timed_out = 0;
            n_cancelled = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                words++;
                if (duty_q.size() == 0) begin
                    if (fails < 10)
                        $display("[%0t] duty word with none expected: L=%0d R=%0d status=%0d",
                                 $time, i_res.left_duty, i_res.right_duty, i_res.move_status);
                    fails++;
                end else begin
                    want = duty_q.pop_front();
                    bad  = (i_res.left_duty !== want.left_duty)
                        || (i_res.right_duty !== want.right_duty)
                        || (i_res.move_status !== want.status);
                    if (bad) begin
                        if (fails < 10) begin
                            $write("[%0t] duty word %0d: expected L=%0d R=%0d status=%s,",
                                   $time, words, want.left_duty, want.right_duty,
                                   want.status.name());
                            $display(" got L=%0d R=%0d status=%0d",
                                     i_res.left_duty, i_res.right_duty, i_res.move_status);
                        end
                        fails++;
                    end
                    case (want.status)
                        ST_REACHED: n_reached++;
                        ST_TIMEOUT: n_timed_out++;
                        ST_CANCEL:  n_cancelled++;
                        default: ;
                    endcase
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                duty_q.push_back(predict_duties(i_cmd.left_position, i_cmd.right_position,
                                                i_cmd.start_move, i_cmd.cancel));
            if (psel && penable && pwrite && pready) begin
                case (paddr[REG_IDX_BITS+1:2])
                    REG_TARGET:   regs.target_position <= pwdata[CFG_POS_BITS-1:0];
                    REG_MAX_DUTY: regs.max_duty        <= pwdata[DUTY_MAG_BITS-1:0];
                    REG_MIN_DUTY: regs.min_duty        <= pwdata[DUTY_MAG_BITS-1:0];
                    REG_APP_GAIN: regs.approach_gain   <= pwdata[GAIN_BITS-1:0];
                    REG_SYN_GAIN: regs.sync_gain       <= pwdata[GAIN_BITS-1:0];
                    REG_TOL:      regs.tolerance       <= pwdata[14:0];
                    REG_DEADBAND: regs.deadband        <= pwdata[14:0];
                    REG_TIMEOUT:  regs.timeout_ticks   <= pwdata[TIMEOUT_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count    <= fails;
        o_pending       <= duty_q.size();
        o_words_checked <= words;
        o_reached       <= n_reached;
        o_timed_out     <= n_timed_out;
        o_cancelled     <= n_cancelled;
    end

endmodule

@@ test/tb_dual_motor_synced_position_loop_top.sv @@
// Testbench top for the dual motor position loop: clock, reset, ticks, registers, verdict.
`timescale 1ns / 1ps

module tb_dual_motor_synced_position_loop_top;
    import dmsp_pkg::*;

    localparam int RUN_LIMIT    = 600000;   // cycles; slowest legal run is far below this
    localparam int SETTLE_WAIT  = 16;       // extra wait after the last expected word, with margin
    localparam int PHASE_TICKS  = 70;       // random ticks per register setting
    localparam int N_PHASES     = 8;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,        // always ready
        RX_THIN,        // one stalled phase out of every four
        RX_RANDOM,      // ~30% random stalls
        RX_BURSTY       // long stall windows
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // configuration port
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    dmsp_in_if  cmd_if ();
    dmsp_out_if res_if ();

    // checker status
    int fail_count;
    int pending;
    int words_checked;
    int n_reached;
    int n_timed_out;
    int n_cancelled;

    // stimulus bookkeeping
    int                 cycles      = 0;
    int                 burst_left  = 0;
    int                 ticks_sent  = 0;
    int                 settings_used = 0;
    logic signed [15:0] target_now  = '0;

    // receiver side
    logic     rx_ready    = 1'b0;
    logic [5:0] rx_phase  = '0;
    t_rx_mode rx_mode     = RX_OPEN;

    always #6 i_clk = ~i_clk;

    dual_motor_synced_position_loop_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    dmsp_tick_checker u_duty_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_cmd           (cmd_if),
        .i_res           (res_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_reached       (n_reached),
        .o_timed_out     (n_timed_out),
        .o_cancelled     (n_cancelled)
    );

    assign res_if.ready = rx_ready;

    // Receiver: pattern redrawn at each phase wrap so stalls hit every tick phase.
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase == '0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   rx_ready <= 1'b1;
            RX_THIN:   rx_ready <= rx_phase[1:0] != 2'd3;
            RX_RANDOM: rx_ready <= $urandom_range(0, 9) > 2;
            default:   rx_ready <= rx_phase[4:0] < 5'd12;  // stalled for the upper part of each phase window
        endcase
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int clip16(input int v);
        if (v > 32767)  return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // uniform in [-m, m]
    function automatic int jitter(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input t_cfg c);
        reg_write(REG_TARGET,   32'(c.target_position));
        reg_write(REG_MAX_DUTY, 32'(c.max_duty));
        reg_write(REG_MIN_DUTY, 32'(c.min_duty));
        reg_write(REG_APP_GAIN, 32'(c.approach_gain));
        reg_write(REG_SYN_GAIN, 32'(c.sync_gain));
        reg_write(REG_TOL,      32'(c.tolerance));
        reg_write(REG_DEADBAND, 32'(c.deadband));
        reg_write(REG_TIMEOUT,  32'(c.timeout_ticks));
        target_now = c.target_position;
        settings_used++;
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.target_position = 16'($urandom);
        c.max_duty        = 15'($urandom_range(0, 32767));
        c.min_duty        = 15'($urandom_range(0, 32767));
        c.approach_gain   = 16'($urandom);
        c.sync_gain       = 16'($urandom);
        // mostly narrow bands so moves do not end on their first tick
        c.tolerance = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1500));
        c.deadband  = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1500));
        c.timeout_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 40));
        return c;
    endfunction

    // One tick word. The sender runs in bursts; a nonzero gap between bursts drops valid.
    task automatic send_tick(input int lp, input int rp, input bit start, input bit abort);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.left_position  <= 16'(lp);
        cmd_if.right_position <= 16'(rp);
        cmd_if.start_move     <= start;
        cmd_if.cancel         <= abort;
        do @(posedge i_clk); while (!cmd_if.ready);
        burst_left--;
        ticks_sent++;
    endtask

    // Drop valid and wait until every expected word is back, plus the block's latency.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // A move: start tick, then positions converging on the target with skew and noise.
    // Occasional cancels, and now and then a move that never gets its start tick.
    task automatic drive_move();
        int lp;
        int rp;
        int span;
        int n_ticks;
        bit with_start;
        case ($urandom_range(0, 3))
            0:       span = 64;
            1:       span = 1024;
            2:       span = 8192;
            default: span = 32767;
        endcase
        n_ticks    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 14);
        with_start = $urandom_range(0, 7) != 0;
        lp = clip16(int'(target_now) + jitter(span));
        rp = clip16(lp + jitter(($urandom_range(0, 1) == 0) ? 600 : 6000));
        for (int k = 0; k < n_ticks; k++) begin
            send_tick(lp, rp, with_start && k == 0, $urandom_range(0, 29) == 0);
            lp = clip16(lp + (int'(target_now) - lp) / int'($urandom_range(2, 5)) + jitter(40));
            rp = clip16(rp + (int'(target_now) - rp) / int'($urandom_range(2, 5)) + jitter(40));
        end
    endtask

    // Unstructured tick: any positions, random flags.
    task automatic send_noise();
        send_tick(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                  $urandom_range(0, 1), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        t_cfg pick;
        int   phase_goal;

        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        cmd_if.valid          <= 1'b0;
        cmd_if.left_position  <= '0;
        cmd_if.right_position <= '0;
        cmd_if.start_move     <= 1'b0;
        cmd_if.cancel         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset register values (target 0, tol 492, deadband 328) ----
        send_tick(0, 0, 1, 0);               // both on target: reached at once
        send_tick(20000, -3000, 0, 0);       // held reached, positions ignored
        send_tick(-32768, 32767, 1, 0);      // full-scale skew, right leads, slowdown to 0
        send_tick(32767, -32768, 1, 0);      // reverse direction, left slowed
        send_tick(0, 2000, 1, 0);            // left in band but slowed right still driven
        send_tick(8000, 8000, 1, 0);         // equal positions: no slowdown
        send_tick(4000, 4328, 1, 0);         // skew exactly at deadband: ignored
        send_tick(4000, 4329, 1, 0);         // one past deadband: slowdown
        send_tick(492, -492, 1, 0);          // both exactly at tolerance: reached
        send_tick(493, 493, 1, 0);           // just outside tolerance
        send_tick(-1000, -1000, 1, 0);       // forward drive
        send_tick(-600, -500, 0, 0);         // continuing move
        send_tick(-300, -300, 0, 1);         // cancel mid-move
        send_tick(0, 0, 0, 0);               // held cancel wins over reached
        send_tick(100, 100, 0, 1);           // cancel while ended: ignored
        send_tick(5000, 5000, 1, 1);         // start and cancel together
        send_tick(32767, 32767, 1, 0);       // max error, duty clamps at max
        send_tick(-32768, -32768, 1, 0);     // min position
        wait_drained();

        // timeout at zero allowed ticks: second moving tick times out
        reg_write(REG_TIMEOUT, 32'd0);
        send_tick(5000, 5000, 1, 0);
        send_tick(5000, 5000, 0, 0);
        send_tick(5000, 5000, 0, 1);         // held timeout ignores cancel
        send_tick(0, 0, 1, 0);               // restart clears the end
        wait_drained();

        // ---- random phases, extremes interleaved ----
        for (int ph = 0; ph < N_PHASES; ph++) begin
            pick = random_settings();
            case (ph)
                1: begin
                    pick.target_position = 16'sh8000;
                    pick.max_duty        = 15'h7FFF;
                    pick.min_duty        = '0;
                    pick.approach_gain   = 16'hFFFF;
                    pick.sync_gain       = 16'hFFFF;
                    pick.tolerance       = '0;
                    pick.deadband        = '0;
                    pick.timeout_ticks   = '0;
                end
                3: begin
                    // crossed limits: max wins; widest bands, no timeout reachable
                    pick.target_position = 16'sh7FFF;
                    pick.max_duty        = '0;
                    pick.min_duty        = 15'h7FFF;
                    pick.approach_gain   = '0;
                    pick.sync_gain       = '0;
                    pick.tolerance       = 15'h7FFF;
                    pick.deadband        = 15'h7FFF;
                    pick.timeout_ticks   = 16'hFFFF;
                end
                5: begin
                    pick.target_position = '0;
                    pick.max_duty        = 15'h7FFF;
                    pick.min_duty        = 15'h7FFF;
                    pick.approach_gain   = 16'd1;
                    pick.sync_gain       = 16'd1;
                    pick.tolerance       = 15'd0;
                    pick.deadband        = 15'd0;
                    pick.timeout_ticks   = 16'd3;
                end
                default: ;
            endcase
            load_settings(pick);
            phase_goal = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_goal) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else drive_move();
            end
            wait_drained();
        end

        $display("Checked %0d duty words from %0d ticks across %0d register settings.",
                 words_checked, ticks_sent, settings_used + 2);
        $display("Move ends seen: %0d reached, %0d timed out, %0d cancelled.",
                 n_reached, n_timed_out, n_cancelled);
        if (pending != 0)
            $display("%0d expected duty words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
